// ===== hw/rtl/iulm_pkg.sv =====
`timescale 1ns / 1ps
package iulm_pkg;

   // report geometry
   localparam int REPORT_BYTES = 8;
   localparam int REPORT_W     = REPORT_BYTES * 8;

   // iteration counts of the shared arithmetic
   localparam int DIV_STEPS  = 64;
   localparam int SQRT_STEPS = 16;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   // item opcodes
   localparam logic [1:0] OP_EDGE       = 2'd0;
   localparam logic [1:0] OP_REPORT     = 2'd1;
   localparam logic [1:0] OP_CLEAR_STAT = 2'd2;
   localparam logic [1:0] OP_CLEAR_PREV = 2'd3;

   // detection modes
   localparam logic [1:0] MODE_CLICK    = 2'd0;
   localparam logic [1:0] MODE_MOTION   = 2'd1;
   localparam logic [1:0] MODE_KEYBOARD = 2'd2;

   // report protocols
   localparam logic [1:0] PROTO_MOUSE    = 2'd0;
   localparam logic [1:0] PROTO_KEYBOARD = 2'd1;

   // configuration register indexes
   localparam logic [1:0] CSR_MODE    = 2'd0;
   localparam logic [1:0] CSR_HOLDOFF = 2'd1;
   localparam logic [1:0] CSR_REPID   = 2'd2;
   localparam logic [1:0] CSR_MASK    = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic exec;
      logic accum;
      logic div_init;
      logic div_step;
      logic mul;
      logic sqrt_init;
      logic sqrt_step;
      logic out_load;
   } cmd_type;

endpackage

// ===== hw/rtl/iulm_dp.sv =====
`timescale 1ns / 1ps
module iulm_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  iulm_pkg::cmd_type            cmd,
   input  logic                         csr_write_enable,
   input  logic [1:0]                   csr_index,
   input  logic [63:0]                  csr_write_data,
   input  logic [1:0]                   req_opcode,
   input  logic [31:0]                  req_time_us,
   input  logic [iulm_pkg::REPORT_W-1:0] req_report_bytes,
   input  logic [3:0]                   req_report_length,
   input  logic [1:0]                   req_protocol,
   output logic                         rsp_edge_accepted,
   output logic                         rsp_measured,
   output logic [30:0]                  rsp_last_latency,
   output logic [31:0]                  rsp_sample_count,
   output logic [31:0]                  rsp_mean_us,
   output logic [31:0]                  rsp_variance_us2,
   output logic [15:0]                  rsp_latency_sd
);

   // configuration
   logic [1:0]  mode_ff;
   logic [31:0] holdoff_ff;
   logic [7:0]  rep_id_ff;
   logic [iulm_pkg::REPORT_W-1:0] mask_ff;

   // measurement state
   logic [31:0] last_edge_ff, last_edge_in;
   logic        pending_ff, pending_in;
   logic [iulm_pkg::REPORT_W-1:0] prev_ff, prev_in;
   logic [30:0] last_lat_ff;
   logic [63:0] sum_ff, sq_ff;
   logic [31:0] count_ff;

   // per-item results of the decode
   logic        acc_ff, acc_in;
   logic        take_ff, take_in;
   logic [30:0] diff_ff;

   // dividers, multiply, root
   logic [31:0] rem_a_ff, rem_b_ff;
   logic [63:0] quo_a_ff, quo_b_ff;
   logic [31:0] var_ff;
   logic [31:0] sq_v_ff, sq_root_ff, sq_bit_ff;

   // output register
   logic        o_acc_ff, o_meas_ff;
   logic [30:0] o_lat_ff;
   logic [31:0] o_cnt_ff, o_mean_ff, o_var_ff;
   logic [15:0] o_sd_ff;

   // decode of the incoming item
   logic [3:0]  len;
   logic [iulm_pkg::REPORT_W-1:0] rep_m, cand;
   logic [31:0] diff;
   logic        id_ok, mouse_hit, kb_any, kb_hit, hit;

   always_comb begin
      len = (req_report_length > 4'(iulm_pkg::REPORT_BYTES)) ?
            4'(iulm_pkg::REPORT_BYTES) : req_report_length;
      for (int i = 0; i < iulm_pkg::REPORT_BYTES; i++) begin
         rep_m[i*8 +: 8] = (4'(i) < len) ? req_report_bytes[i*8 +: 8] : 8'd0;
      end
      id_ok = (rep_id_ff == 8'd0) || (rep_m[7:0] == rep_id_ff);
      case (mode_ff)
         iulm_pkg::MODE_CLICK:  cand = rep_m & ~prev_ff & mask_ff;
         iulm_pkg::MODE_MOTION: cand = rep_m & mask_ff;
         default:               cand = '0;
      endcase
      // with an ID byte present, byte 0 is not scanned
      if (rep_id_ff != 8'd0) begin
         cand[7:0] = 8'd0;
      end
      mouse_hit = (req_protocol == iulm_pkg::PROTO_MOUSE) && id_ok && (|cand);
      kb_any = (rep_m[7:0] != 8'd0);
      for (int i = 2; i < iulm_pkg::REPORT_BYTES; i++) begin
         kb_any = kb_any | (rep_m[i*8 +: 8] > 8'd1);
      end
      kb_hit = (mode_ff == iulm_pkg::MODE_KEYBOARD) && kb_any &&
               (((req_protocol == iulm_pkg::PROTO_MOUSE) && id_ok) ||
                (req_protocol == iulm_pkg::PROTO_KEYBOARD));
      hit  = (req_opcode == iulm_pkg::OP_REPORT) && (mouse_hit || kb_hit);
      diff = req_time_us - last_edge_ff;

      last_edge_in = last_edge_ff;
      pending_in   = pending_ff;
      prev_in      = prev_ff;
      acc_in       = 1'b0;
      take_in      = 1'b0;
      case (req_opcode)
         iulm_pkg::OP_EDGE: begin
            if (diff >= holdoff_ff) begin
               last_edge_in = req_time_us;
               pending_in   = 1'b1;
               acc_in       = 1'b1;
            end
         end
         iulm_pkg::OP_REPORT: begin
            if ((req_protocol == iulm_pkg::PROTO_MOUSE) && id_ok) begin
               prev_in = rep_m;
            end
            if (hit && pending_ff) begin
               pending_in = 1'b0;
               take_in    = ~diff[31];
            end
         end
         iulm_pkg::OP_CLEAR_PREV: prev_in = '0;
         default: ;
      endcase
   end

   // divider step terms
   logic [32:0] sh_a, sh_b;
   logic        ge_a, ge_b;
   logic [31:0] sq_try;
   logic [61:0] sq_prod;
   always_comb begin
      sh_a    = {rem_a_ff, quo_a_ff[63]};
      sh_b    = {rem_b_ff, quo_b_ff[63]};
      ge_a    = sh_a >= {1'b0, count_ff};
      ge_b    = sh_b >= {1'b0, count_ff};
      sq_try  = sq_root_ff + sq_bit_ff;
      // 31 by 31 bit square of the sample
      sq_prod = diff_ff * diff_ff;
   end

   // control state: configuration and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         holdoff_ff   <= '0;
         rep_id_ff    <= '0;
         mask_ff      <= '0;
         last_edge_ff <= '0;
         pending_ff   <= 1'b0;
         prev_ff      <= '0;
         last_lat_ff  <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         count_ff     <= '0;
         acc_ff       <= 1'b0;
         take_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               iulm_pkg::CSR_MODE:    mode_ff    <= csr_write_data[1:0];
               iulm_pkg::CSR_HOLDOFF: holdoff_ff <= csr_write_data[31:0];
               iulm_pkg::CSR_REPID:   rep_id_ff  <= csr_write_data[7:0];
               iulm_pkg::CSR_MASK:    mask_ff    <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.exec) begin
            last_edge_ff <= last_edge_in;
            pending_ff   <= pending_in;
            prev_ff      <= prev_in;
            acc_ff       <= acc_in;
            take_ff      <= take_in;
            if (req_opcode == iulm_pkg::OP_CLEAR_STAT) begin
               last_lat_ff <= '0;
               sum_ff      <= '0;
               sq_ff       <= '0;
               count_ff    <= '0;
            end
         end
         // fold a new sample into the sums
         if (cmd.accum && take_ff) begin
            last_lat_ff <= diff_ff;
            sum_ff      <= sum_ff + 64'(diff_ff);
            sq_ff       <= sq_ff + 64'(sq_prod);
            count_ff    <= count_ff + 32'd1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         diff_ff <= diff[30:0];
      end
      // two restoring dividers side by side: sum and sum of squares by count
      if (cmd.div_init) begin
         rem_a_ff <= '0;
         rem_b_ff <= '0;
         quo_a_ff <= sum_ff;
         quo_b_ff <= sq_ff;
      end
      if (cmd.div_step) begin
         rem_a_ff <= ge_a ? 32'(sh_a - {1'b0, count_ff}) : sh_a[31:0];
         rem_b_ff <= ge_b ? 32'(sh_b - {1'b0, count_ff}) : sh_b[31:0];
         quo_a_ff <= {quo_a_ff[62:0], ge_a};
         quo_b_ff <= {quo_b_ff[62:0], ge_b};
      end
      // only the low 32 bits of the variance are kept
      if (cmd.mul) begin
         var_ff <= quo_b_ff[31:0] - quo_a_ff[31:0] * quo_a_ff[31:0];
      end
      // bit-pair integer square root
      if (cmd.sqrt_init) begin
         sq_v_ff    <= var_ff;
         sq_root_ff <= '0;
         sq_bit_ff  <= 32'h4000_0000;
      end
      if (cmd.sqrt_step) begin
         if (sq_v_ff >= sq_try) begin
            sq_v_ff    <= sq_v_ff - sq_try;
            sq_root_ff <= (sq_root_ff >> 1) + sq_bit_ff;
         end else begin
            sq_root_ff <= sq_root_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
      if (cmd.out_load) begin
         o_acc_ff  <= acc_ff;
         o_meas_ff <= take_ff;
         o_lat_ff  <= last_lat_ff;
         o_cnt_ff  <= count_ff;
         if (count_ff == 32'd0) begin
            o_mean_ff <= '0;
            o_var_ff  <= '0;
            o_sd_ff   <= '0;
         end else begin
            o_mean_ff <= quo_a_ff[31:0];
            o_var_ff  <= var_ff;
            o_sd_ff   <= sq_root_ff[15:0];
         end
      end
   end

   assign rsp_edge_accepted = o_acc_ff;
   assign rsp_measured      = o_meas_ff;
   assign rsp_last_latency  = o_lat_ff;
   assign rsp_sample_count  = o_cnt_ff;
   assign rsp_mean_us       = o_mean_ff;
   assign rsp_variance_us2  = o_var_ff;
   assign rsp_latency_sd    = o_sd_ff;

endmodule

// ===== hw/rtl/iulm_ctrl.sv =====
`timescale 1ns / 1ps
module iulm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iulm_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_ACCUM, ST_DIV_INIT, ST_DIV, ST_MUL, ST_SQRT_INIT, ST_SQRT, ST_DONE
   } state_type;

   state_type                   state_ff;
   logic [iulm_pkg::CNT_W-1:0]  cnt_ff;
   logic                        rsp_valid_ff;
   logic                        out_free;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // commands decoded from state
   always_comb begin
      cmd           = '0;
      cmd.exec      = (state_ff == ST_IDLE) && req_valid;
      cmd.accum     = (state_ff == ST_ACCUM);
      cmd.div_init  = (state_ff == ST_DIV_INIT);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.mul       = (state_ff == ST_MUL);
      cmd.sqrt_init = (state_ff == ST_SQRT_INIT);
      cmd.sqrt_step = (state_ff == ST_SQRT);
      cmd.out_load  = (state_ff == ST_DONE) && out_free;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequencer, step counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_ACCUM;
               end
            end
            ST_ACCUM:    state_ff <= ST_DIV_INIT;
            ST_DIV_INIT: begin
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == iulm_pkg::CNT_W'(iulm_pkg::DIV_STEPS - 1)) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL:       state_ff <= ST_SQRT_INIT;
            ST_SQRT_INIT: begin
               cnt_ff   <= '0;
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == iulm_pkg::CNT_W'(iulm_pkg::SQRT_STEPS - 1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // a loaded result is offered next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("result loaded but not offered");

   // never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && rsp_stall))
      else $error("waiting result overwritten");

   // the root runs its fixed number of steps only
   a_sqrt_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |->
         (cnt_ff < iulm_pkg::CNT_W'(iulm_pkg::SQRT_STEPS)))
      else $error("square root overran");

   // an accepted item always leads into the sums step
   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> (state_ff == ST_ACCUM))
      else $error("accepted item not sequenced");

endmodule

// ===== hw/rtl/input_to_usb_latency_meter.sv =====
`timescale 1ns / 1ps
// Trigger-to-USB-report latency meter. Each item (trigger edge, USB report,
// statistics clear or previous-report clear) yields exactly one result item
// carrying the edge and sample flags, the last latency, the sample count and
// the mean, variance and floor square-root of variance of all samples. The
// item is decoded and registered at the edge that accepts it. It then passes
// in order through the sum and square update, the two 64-by-32 bit restoring
// dividers running side by side, the variance multiply and the bit-pair
// square root, and the result is offered after the output register is loaded.
// A result held by the receiver delays that load. The next item is taken the
// cycle after the load, even if that result has not yet been collected, so
// no item is accepted while an earlier item is still in these steps.
module input_to_usb_latency_meter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [1:0]                   csr_index,
   input  logic [63:0]                  csr_write_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic [31:0]                  req_time_us,
   input  logic [iulm_pkg::REPORT_W-1:0] req_report_bytes,
   input  logic [3:0]                   req_report_length,
   input  logic [1:0]                   req_protocol,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_edge_accepted,
   output logic                         rsp_measured,
   output logic [30:0]                  rsp_last_latency,
   output logic [31:0]                  rsp_sample_count,
   output logic [31:0]                  rsp_mean_us,
   output logic [31:0]                  rsp_variance_us2,
   output logic [15:0]                  rsp_latency_sd
);

   iulm_pkg::cmd_type cmd;

   iulm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   iulm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_opcode        (req_opcode),
      .req_time_us       (req_time_us),
      .req_report_bytes  (req_report_bytes),
      .req_report_length (req_report_length),
      .req_protocol      (req_protocol),
      .rsp_edge_accepted (rsp_edge_accepted),
      .rsp_measured      (rsp_measured),
      .rsp_last_latency  (rsp_last_latency),
      .rsp_sample_count  (rsp_sample_count),
      .rsp_mean_us       (rsp_mean_us),
      .rsp_variance_us2  (rsp_variance_us2),
      .rsp_latency_sd    (rsp_latency_sd)
   );

endmodule
